// File: src/tlb_page_table_lru_translator_core_defines.svh
// Assertion macros for the translator checker. They expect clk and rst in scope.
`ifndef TLB_PAGE_TABLE_LRU_TRANSLATOR_CORE_DEFINES_SVH
`define TLB_PAGE_TABLE_LRU_TRANSLATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLBT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("translator check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define TLBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("translator check failed one cycle later");

`endif

// File: src/tlbt_pkg.sv
// ----------------------------------------------------------------------------
// tlbt_pkg
// Sizes, controller states and the command and status groups of the
// address translator.
// ----------------------------------------------------------------------------
package tlbt_pkg;

  localparam int OFFSET_BITS = 8;
  localparam int VA_W        = 16;
  localparam int PA_W        = 15;
  localparam int PAGE_W      = VA_W - OFFSET_BITS;
  localparam int PAGES       = 256;
  localparam int TLB_ENTRIES = 16;
  localparam int TLB_W       = $clog2(TLB_ENTRIES);
  localparam int FRAMES      = 128;
  localparam int FRAME_W     = $clog2(FRAMES);
  localparam int FCNT_W      = FRAME_W + 1;
  localparam int AGE_BITS    = 16;
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SWEEP,
    S_DRAIN,
    S_DECIDE,
    S_VREAD,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic look;
    logic sweep_rd;
    logic victim_rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic need_victim;
    logic out_free;
  } stat_t;

endpackage

// File: src/tlbt_channels.sv
// ----------------------------------------------------------------------------
// tlbt channels
// Valid/ready channels for the virtual address and the translation result.
// ----------------------------------------------------------------------------
interface tlbt_req_if;
  logic                      valid;
  logic                      ready;
  logic [tlbt_pkg::VA_W-1:0] virtual_address;
  modport source (output valid, output virtual_address, input ready);
  modport sink (input valid, input virtual_address, output ready);
endinterface

interface tlbt_res_if;
  logic                        valid;
  logic                        ready;
  logic [tlbt_pkg::PA_W-1:0]   phys_addr;
  logic                        tlb_hit;
  logic                        page_fault;
  logic                        evicted;
  logic [tlbt_pkg::PAGE_W-1:0] evict_page;
  modport source (output valid, output phys_addr, output tlb_hit,
                  output page_fault, output evicted, output evict_page,
                  input ready);
  modport sink (input valid, input phys_addr, input tlb_hit,
                input page_fault, input evicted, input evict_page,
                output ready);
endinterface

// File: src/tlbt_ctrl.sv
// ----------------------------------------------------------------------------
// tlbt_ctrl
// Sequencer: lookup, page-table sweep, victim read and commit of one item.
// ----------------------------------------------------------------------------
module tlbt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tlbt_pkg::stat_t stat,
  output tlbt_pkg::cmd_t  cmd
);

  tlbt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlbt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tlbt_pkg::S_IDLE:   if (in_valid) state_next = tlbt_pkg::S_LOOK;
      tlbt_pkg::S_LOOK:   state_next = tlbt_pkg::S_SWEEP;
      tlbt_pkg::S_SWEEP:  if (stat.sweep_last) state_next = tlbt_pkg::S_DRAIN;
      tlbt_pkg::S_DRAIN:  state_next = tlbt_pkg::S_DECIDE;
      tlbt_pkg::S_DECIDE: begin
        state_next = stat.need_victim ? tlbt_pkg::S_VREAD : tlbt_pkg::S_COMMIT;
      end
      tlbt_pkg::S_VREAD:  state_next = tlbt_pkg::S_COMMIT;
      tlbt_pkg::S_COMMIT: if (stat.out_free) state_next = tlbt_pkg::S_IDLE;
      default:            state_next = tlbt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      tlbt_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      tlbt_pkg::S_LOOK:   cmd.look      = 1'b1;
      tlbt_pkg::S_SWEEP:  cmd.sweep_rd  = 1'b1;
      tlbt_pkg::S_VREAD:  cmd.victim_rd = 1'b1;
      tlbt_pkg::S_COMMIT: cmd.commit    = stat.out_free;
      default: ;
    endcase
  end

endmodule

// File: src/tlbt_datapath.sv
// ----------------------------------------------------------------------------
// tlbt_datapath
// TLB, page table, age memory, frame allocator and result register.
// ----------------------------------------------------------------------------
module tlbt_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  tlbt_pkg::cmd_t              cmd,
  output tlbt_pkg::stat_t             stat,
  input  logic [tlbt_pkg::VA_W-1:0]   virtual_address,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [tlbt_pkg::PA_W-1:0]   phys_addr,
  output logic                        tlb_hit,
  output logic                        page_fault,
  output logic                        evicted,
  output logic [tlbt_pkg::PAGE_W-1:0] evict_page
);

  localparam int PW = tlbt_pkg::PAGE_W;
  localparam int FW = tlbt_pkg::FRAME_W;
  localparam int TE = tlbt_pkg::TLB_ENTRIES;
  localparam int AW = tlbt_pkg::AGE_BITS;

  // TLB
  logic [PW-1:0]              tlb_page  [TE];
  logic [FW-1:0]              tlb_frame [TE];
  logic [TE-1:0]              tlb_valid;
  logic [tlbt_pkg::TLB_W-1:0] fifo_head;

  // Page table
  logic [FW-1:0]                 frame_mem [tlbt_pkg::PAGES];
  logic [FW-1:0]                 frame_rd;
  logic [tlbt_pkg::PAGES-1:0]    page_valid;
  logic [AW-1:0]                 age_mem [tlbt_pkg::PAGES];
  logic [AW-1:0]                 age_rd;
  logic [tlbt_pkg::FCNT_W-1:0]   used_cnt;

  // Item registers
  logic [PW-1:0]                   page;
  logic [tlbt_pkg::OFFSET_BITS-1:0] offset;
  logic                            hit;
  logic [FW-1:0]                   hit_frame;
  logic                            pt_valid;

  // Sweep
  logic [PW-1:0] sweep_idx;
  logic [PW-1:0] proc_idx;
  logic          proc_valid;
  logic [AW-1:0] best;
  logic [PW-1:0] victim;
  logic          any;

  logic          fault, no_free, evict;
  logic          look_hit;
  logic [FW-1:0] look_frame;
  logic [FW-1:0] frame;
  logic [TE-1:0] victim_match, tlb_valid_mid, tlb_valid_next;
  logic [tlbt_pkg::PAGES-1:0] page_valid_next;
  logic          free_slot_found;
  logic [tlbt_pkg::TLB_W-1:0] free_slot, refill_slot;
  logic          proc_ok;

  assign fault   = !hit && !pt_valid;
  assign no_free = (used_cnt == tlbt_pkg::FCNT_W'(tlbt_pkg::FRAMES));
  assign evict   = fault && no_free && any;
  assign proc_ok = proc_valid && page_valid[proc_idx];

  assign stat.sweep_last  = (sweep_idx == PW'(tlbt_pkg::PAGES - 1));
  assign stat.need_victim = evict;
  assign stat.out_free    = !res_valid || res_ready;

  // Associative TLB lookup; a page sits in at most one entry.
  always_comb begin
    look_hit   = 1'b0;
    look_frame = '0;
    for (int i = 0; i < TE; i++) begin
      if (tlb_valid[i] && tlb_page[i] == page && !look_hit) begin
        look_hit   = 1'b1;
        look_frame = tlb_frame[i];
      end
    end
  end

  always_comb begin
    if (hit) begin
      frame = hit_frame;
    end else if (!fault || evict) begin
      frame = frame_rd;
    end else if (!no_free) begin
      frame = used_cnt[FW-1:0];
    end else begin
      frame = '0;
    end
  end

  // The victim's entry is dropped before the refill looks for a free slot.
  always_comb begin
    for (int i = 0; i < TE; i++) begin
      victim_match[i] = evict && tlb_valid[i] && tlb_page[i] == victim;
    end
    tlb_valid_mid   = tlb_valid & ~victim_match;
    free_slot_found = 1'b0;
    free_slot       = '0;
    for (int i = 0; i < TE; i++) begin
      if (!tlb_valid_mid[i] && !free_slot_found) begin
        free_slot_found = 1'b1;
        free_slot       = tlbt_pkg::TLB_W'(i);
      end
    end
    refill_slot = free_slot_found ? free_slot : fifo_head;
  end

  always_comb begin
    tlb_valid_next              = tlb_valid_mid;
    tlb_valid_next[refill_slot] = 1'b1;
    page_valid_next             = page_valid;
    if (evict) begin
      page_valid_next[victim] = 1'b0;
    end
    page_valid_next[page] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page   <= virtual_address[tlbt_pkg::VA_W-1:tlbt_pkg::OFFSET_BITS];
      offset <= virtual_address[tlbt_pkg::OFFSET_BITS-1:0];
    end
    if (cmd.look) begin
      hit       <= look_hit;
      hit_frame <= look_frame;
      pt_valid  <= page_valid[page];
    end
  end

  // Page-frame memory: one port, registered read.
  always_ff @(posedge clk) begin
    if (cmd.commit && fault) begin
      frame_mem[page] <= frame;
    end else if (cmd.look) begin
      frame_rd <= frame_mem[page];
    end else if (cmd.victim_rd) begin
      frame_rd <= frame_mem[victim];
    end
  end

  // Age memory: the sweep reads one page a cycle and writes the aged value back
  // in the following cycle; invalid pages are left alone.
  always_ff @(posedge clk) begin
    if (cmd.sweep_rd) begin
      age_rd <= age_mem[sweep_idx];
    end
    if (cmd.commit) begin
      age_mem[page] <= '0;
    end else if (proc_ok) begin
      age_mem[proc_idx] <= (age_rd == tlbt_pkg::AGE_MAX) ? age_rd : age_rd + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      sweep_idx <= '0;
    end else if (cmd.sweep_rd) begin
      sweep_idx <= sweep_idx + PW'(1);
    end
    proc_idx <= sweep_idx;
    // Ties favor the later page, so the compare is greater or equal.
    if (cmd.look) begin
      best   <= '0;
      victim <= '0;
      any    <= 1'b0;
    end else if (proc_ok && age_rd >= best) begin
      best   <= age_rd;
      victim <= proc_idx;
      any    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_valid <= 1'b0;
    end else begin
      proc_valid <= cmd.sweep_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_valid  <= '0;
      fifo_head  <= '0;
      page_valid <= '0;
      used_cnt   <= '0;
    end else if (cmd.commit && !hit) begin
      tlb_valid <= tlb_valid_next;
      if (!free_slot_found) begin
        fifo_head <= fifo_head + tlbt_pkg::TLB_W'(1);
      end
      if (fault) begin
        page_valid <= page_valid_next;
        if (!no_free) begin
          used_cnt <= used_cnt + tlbt_pkg::FCNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !hit) begin
      tlb_page[refill_slot]  <= page;
      tlb_frame[refill_slot] <= frame;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      phys_addr  <= {frame, offset};
      tlb_hit    <= hit;
      page_fault <= fault;
      evicted    <= evict;
      evict_page <= evict ? victim : '0;
    end
  end

endmodule

// File: src/tlb_page_table_lru_translator_core.sv
// Each accepted item runs through lookup, an age sweep over all PAGES page-table
// entries, drain, decide, a victim read only when a victim page is evicted, and
// commit, which loads the result register; commit waits while the previous
// result is still waiting, and the next item is accepted back in idle. The age
// sweep reads and writes back one page-table entry per cycle on every item.
// Reset: synchronous, active high; clears valid bits, FIFO head, fill count, FSM.
// ----------------------------------------------------------------------------
// tlb_page_table_lru_translator_core
// Virtual-to-physical translation with a TLB, a page table and LRU eviction.
// ----------------------------------------------------------------------------
module tlb_page_table_lru_translator_core (
  input logic clk,
  input logic rst,
  tlbt_req_if.sink   request,
  tlbt_res_if.source result
);

  tlbt_pkg::cmd_t  cmd;
  tlbt_pkg::stat_t stat;

  tlbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (request.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tlbt_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .virtual_address  (request.virtual_address),
    .res_valid        (result.valid),
    .res_ready        (result.ready),
    .phys_addr        (result.phys_addr),
    .tlb_hit          (result.tlb_hit),
    .page_fault       (result.page_fault),
    .evicted          (result.evicted),
    .evict_page       (result.evict_page)
  );

endmodule

// File: src/tlbt_checker.sv
// ----------------------------------------------------------------------------
// tlbt_checker
// Port-level checks of the translator, bound to the top level.
// ----------------------------------------------------------------------------
`include "tlb_page_table_lru_translator_core_defines.svh"

module tlbt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [tlbt_pkg::PA_W-1:0]   phys_addr,
  input logic                        tlb_hit,
  input logic                        page_fault,
  input logic                        evicted,
  input logic [tlbt_pkg::PAGE_W-1:0] evict_page
);

  logic [tlbt_pkg::PA_W+tlbt_pkg::PAGE_W+2:0] res_bits;

  assign res_bits = {phys_addr, tlb_hit, page_fault, evicted, evict_page};

  `TLBT_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_bits))
  `TLBT_ASSERT_NOW(a_evict_fault, res_valid && evicted, page_fault)
  `TLBT_ASSERT_NOW(a_hit_no_fault, res_valid && tlb_hit, !page_fault)
  `TLBT_ASSERT_NOW(a_victim_zero, res_valid && !evicted, evict_page == '0)
  `TLBT_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

endmodule

bind tlb_page_table_lru_translator_core tlbt_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (request.valid),
  .req_ready        (request.ready),
  .res_valid        (result.valid),
  .res_ready        (result.ready),
  .phys_addr        (result.phys_addr),
  .tlb_hit          (result.tlb_hit),
  .page_fault       (result.page_fault),
  .evicted          (result.evicted),
  .evict_page       (result.evict_page)
);

// File: tb/sv/tlb_page_table_lru_translator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_table_lru_translator_core_tb
// Drives virtual addresses into the translator and compares every result with a
// written expectation or a software copy of the TLB, the page table and LRU ages.
// ----------------------------------------------------------------------------
module tlb_page_table_lru_translator_core_tb;

  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int SETTLE       = 300;

  typedef struct packed {
    logic [tlbt_pkg::PA_W-1:0]   phys_addr;
    logic                        tlb_hit;
    logic                        page_fault;
    logic                        evicted;
    logic [tlbt_pkg::PAGE_W-1:0] evict_page;
  } xlat_t;

  typedef struct {
    logic [tlbt_pkg::VA_W-1:0] va;
    bit                        typed;
    xlat_t                     want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  tlbt_req_if request();
  tlbt_res_if result();

  tlb_page_table_lru_translator_core dut (
    .clk(clk), .rst(rst), .request(request.sink), .result(result.source)
  );

  always #5 clk = ~clk;

  // Shadow state of the translator.
  logic [tlbt_pkg::PAGE_W-1:0]   sh_tlb_page  [tlbt_pkg::TLB_ENTRIES];
  logic [tlbt_pkg::FRAME_W-1:0]  sh_tlb_frame [tlbt_pkg::TLB_ENTRIES];
  bit                            sh_tlb_valid [tlbt_pkg::TLB_ENTRIES];
  logic [tlbt_pkg::TLB_W-1:0]    sh_fifo_head;
  logic [tlbt_pkg::FRAME_W-1:0]  sh_page_frame[tlbt_pkg::PAGES];
  bit                            sh_page_valid[tlbt_pkg::PAGES];
  logic [tlbt_pkg::AGE_BITS-1:0] sh_page_age  [tlbt_pkg::PAGES];
  bit                            sh_frame_used[tlbt_pkg::FRAMES];

  xlat_t pending_xlat[$];
  int    mismatches = 0;
  int    cycles = 0;
  int    send_idle_pct = 15;
  int    recv_idle_pct = 61;

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got 0x%0h expected 0x%0h", what, got, want);
    mismatches++;
  endtask

  function automatic void tlb_fill(input int page, input int frame);
    for (int i = 0; i < tlbt_pkg::TLB_ENTRIES; i++) begin
      if (!sh_tlb_valid[i]) begin
        sh_tlb_page[i]  = tlbt_pkg::PAGE_W'(page);
        sh_tlb_frame[i] = tlbt_pkg::FRAME_W'(frame);
        sh_tlb_valid[i] = 1'b1;
        return;
      end
    end
    sh_tlb_page[sh_fifo_head]  = tlbt_pkg::PAGE_W'(page);
    sh_tlb_frame[sh_fifo_head] = tlbt_pkg::FRAME_W'(frame);
    sh_tlb_valid[sh_fifo_head] = 1'b1;
    sh_fifo_head = sh_fifo_head + tlbt_pkg::TLB_W'(1);
  endfunction

  function automatic xlat_t translate(input logic [tlbt_pkg::VA_W-1:0] va);
    xlat_t r;
    int page, frame, best, victim, offs;
    bit found, any;
    page   = int'(va[tlbt_pkg::VA_W-1:tlbt_pkg::OFFSET_BITS]);
    offs   = int'(va[tlbt_pkg::OFFSET_BITS-1:0]);
    frame  = 0;
    found  = 1'b0;
    r      = '0;
    for (int i = 0; i < tlbt_pkg::TLB_ENTRIES; i++) begin
      if (!found && sh_tlb_valid[i] && sh_tlb_page[i] == page) begin
        frame = int'(sh_tlb_frame[i]);
        found = 1'b1;
      end
    end
    if (found) begin
      r.tlb_hit = 1'b1;
    end else if (sh_page_valid[page]) begin
      frame = int'(sh_page_frame[page]);
      tlb_fill(page, frame);
    end else begin
      r.page_fault = 1'b1;
      found = 1'b0;
      for (int i = 0; i < tlbt_pkg::FRAMES; i++) begin
        if (!found && !sh_frame_used[i]) begin
          frame = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        // Oldest resident page goes; equal ages favor the higher page index.
        any = 1'b0;
        best = 0;
        victim = 0;
        for (int i = 0; i < tlbt_pkg::PAGES; i++) begin
          if (sh_page_valid[i] && sh_page_age[i] >= best) begin
            best = int'(sh_page_age[i]);
            victim = i;
            any = 1'b1;
          end
        end
        if (any) begin
          r.evicted = 1'b1;
          r.evict_page = tlbt_pkg::PAGE_W'(victim);
          sh_page_valid[victim] = 1'b0;
          found = 1'b0;
          for (int i = 0; i < tlbt_pkg::TLB_ENTRIES; i++) begin
            if (!found && sh_tlb_valid[i] && sh_tlb_page[i] == victim) begin
              sh_tlb_valid[i] = 1'b0;
              found = 1'b1;
            end
          end
          frame = int'(sh_page_frame[victim]);
        end
      end
      sh_frame_used[frame] = 1'b1;
      tlb_fill(page, frame);
      sh_page_valid[page] = 1'b1;
      sh_page_frame[page] = tlbt_pkg::FRAME_W'(frame);
    end
    for (int i = 0; i < tlbt_pkg::PAGES; i++) begin
      if (sh_page_valid[i] && sh_page_age[i] != tlbt_pkg::AGE_MAX) sh_page_age[i]++;
    end
    sh_page_age[page] = '0;
    r.phys_addr = tlbt_pkg::PA_W'((frame << tlbt_pkg::OFFSET_BITS) | offs);
    return r;
  endfunction

  function automatic xlat_t mk(input int pa, input bit hit, input bit fault);
    xlat_t r;
    r = '0;
    r.phys_addr = tlbt_pkg::PA_W'(pa);
    r.tlb_hit = hit;
    r.page_fault = fault;
    return r;
  endfunction

  // Sends one item and records its expected result at the accepting edge.
  task automatic send(input logic [tlbt_pkg::VA_W-1:0] va, input bit typed,
                      input xlat_t want);
    xlat_t p;
    if ($urandom_range(99) < send_idle_pct) begin
      request.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    request.valid <= 1'b1;
    request.virtual_address <= va;
    do @(posedge clk); while (!request.ready);
    p = translate(va);
    pending_xlat.push_back(typed ? want : p);
  endtask

  function automatic logic [tlbt_pkg::VA_W-1:0] pick_address();
    logic [7:0] page;
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) page = 8'($urandom_range(23));         // hot working set
    else if (sel < 65) page = 8'(8'hF0 + $urandom_range(15));
    else page = 8'($urandom_range(255));
    return {page, 8'($urandom)};
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (result.valid && result.ready) begin
        if (pending_xlat.size() == 0) begin
          report("unexpected result", int'(result.phys_addr), 0);
        end else begin
          xlat_t w;
          w = pending_xlat.pop_front();
          if (result.phys_addr !== w.phys_addr)
            report("phys_addr", int'(result.phys_addr), int'(w.phys_addr));
          if (result.tlb_hit !== w.tlb_hit)
            report("tlb_hit", int'(result.tlb_hit), int'(w.tlb_hit));
          if (result.page_fault !== w.page_fault)
            report("page_fault", int'(result.page_fault), int'(w.page_fault));
          if (result.evicted !== w.evicted)
            report("evicted", int'(result.evicted), int'(w.evicted));
          if (result.evict_page !== w.evict_page)
            report("evict_page", int'(result.evict_page), int'(w.evict_page));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    xlat_t none;
    none = '0;
    request.valid = 1'b0;
    request.virtual_address = '0;
    for (int i = 0; i < tlbt_pkg::TLB_ENTRIES; i++) sh_tlb_valid[i] = 1'b0;
    for (int i = 0; i < tlbt_pkg::PAGES; i++) begin
      sh_page_valid[i] = 1'b0;
      sh_page_age[i] = '0;
    end
    for (int i = 0; i < tlbt_pkg::FRAMES; i++) sh_frame_used[i] = 1'b0;
    sh_fifo_head = '0;

    // First touches after reset fault into frames 0, 1, ...; repeats hit.
    rows.push_back('{16'h0000, 1'b1, mk(15'h0000, 1'b0, 1'b1)});
    rows.push_back('{16'hFFFF, 1'b1, mk(15'h01FF, 1'b0, 1'b1)});
    rows.push_back('{16'h00AB, 1'b1, mk(15'h00AB, 1'b1, 1'b0)});
    rows.push_back('{16'hFF00, 1'b1, mk(15'h0100, 1'b1, 1'b0)});
    rows.push_back('{16'h8055, 1'b1, mk(15'h0255, 1'b0, 1'b1)});
    rows.push_back('{16'h7FAA, 1'b1, mk(15'h03AA, 1'b0, 1'b1)});
    // Eighteen more pages overflow the TLB so that the FIFO slot is used and
    // a table walk refills an entry without a fault.
    for (int i = 1; i <= 18; i++) rows.push_back('{16'(i << 8) | 16'(i), 1'b0, none});
    rows.push_back('{16'h0001, 1'b0, none});

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send(rows[i].va, rows[i].typed, rows[i].want);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 15;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send(pick_address(), 1'b0, none);
    end
    request.valid <= 1'b0;

    while (pending_xlat.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_xlat.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
